// ===== rtl/aed_pkg.sv =====
// Package for the ANSI escape decoder: parse modes, command codes, sequencer states.
// Used by ansi_escape_decoder; depends on nothing.
package aed_pkg;

    typedef enum logic [1:0] {
        MODE_GROUND = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_CSI    = 2'd2
    } t_mode;

    typedef enum logic [4:0] {
        CMD_CHAR     = 5'd0,
        CMD_BELL     = 5'd1,
        CMD_BS       = 5'd2,
        CMD_TAB      = 5'd3,
        CMD_LF       = 5'd4,
        CMD_CR       = 5'd5,
        CMD_SAVE     = 5'd6,
        CMD_RESTORE  = 5'd7,
        CMD_RESET    = 5'd8,
        CMD_UP       = 5'd9,
        CMD_DOWN     = 5'd10,
        CMD_FWD      = 5'd11,
        CMD_BACK     = 5'd12,
        CMD_POS      = 5'd13,
        CMD_ERASE_D  = 5'd14,
        CMD_ERASE_L  = 5'd15,
        CMD_SHOW     = 5'd16,
        CMD_HIDE     = 5'd17,
        CMD_ATTR     = 5'd18
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,     // waiting for an item
        ST_CLEAR,    // clearing the parameter memory after ESC [
        ST_DIGIT,    // read-modify-write of one parameter
        ST_FIN0,     // final byte: first parameter read back
        ST_FIN1,     // final byte: second parameter read back
        ST_SGR,      // walking the stored parameters
        ST_OUT       // result waits in the output register
    } t_state;

    localparam logic [7:0] C_ESC = 8'h1B;
    localparam logic [7:0] C_DEL = 8'h7F;
    localparam logic [15:0] C_SAT = 16'hFFFF;
    localparam logic [15:0] C_VIS = 16'd25;
    localparam logic [15:0] C_FG_EXT = 16'd38;
    localparam logic [15:0] C_BG_EXT = 16'd48;

endpackage

// ===== rtl/ansi_escape_decoder.sv =====
// ANSI escape decoder top level: byte parser around a parameter memory.
// Depends on aed_pkg.
//
//  channel | direction | fields
//  in      | input     | i_stream_byte
//  out     | output    | o_command, o_arg_first, o_arg_second, o_fore_code,
//          |           | o_back_code, o_underline_on, o_blink_on, o_reverse_on
//
// A plain byte with a result goes to ST_OUT; a digit is a memory read, then a write back.
// ESC [ clears the parameter memory in ST_CLEAR, one entry a cycle.
// A final byte reads back parameters in ST_FIN0 and ST_FIN1; SGR then walks them, one a cycle.
// Reset is synchronous; the parameter memory is cleared by the next ESC [ before any read.
// A result holds in the output register until taken; the next item is accepted only then.
module ansi_escape_decoder
    import aed_pkg::*;
#(
    parameter int MAX_PARAMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_command,
    output logic [15:0] o_arg_first,
    output logic [15:0] o_arg_second,
    output logic [4:0]  o_fore_code,
    output logic [4:0]  o_back_code,
    output logic        o_underline_on,
    output logic        o_blink_on,
    output logic        o_reverse_on
);

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_PARAMS);
    localparam logic [AW-1:0] ALAST = AW'(MAX_PARAMS - 1);

    // Parameter memory, one read and one write port, registered read.
    logic [15:0] r_mem [MAX_PARAMS];
    logic [15:0] r_rdata;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        wr_en;
    logic [15:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Control and attribute registers.
    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic r_ovf, n_ovf, r_priv, n_priv;
    logic [7:0] r_byte, n_byte;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_walk, n_walk;
    logic [15:0] r_p0, n_p0;
    logic [3:0] r_fi, n_fi, r_bi, n_bi;
    logic r_fd, n_fd, r_bd, n_bd, r_bold, n_bold, r_ul, n_ul, r_bl, n_bl, r_rv, n_rv;
    t_cmd r_cmd, n_cmd;
    logic [15:0] r_a, n_a, r_b, n_b;
    logic [2:0] r_skip, n_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_GROUND;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_priv  <= 1'b0;
            r_fi    <= '0;
            r_bi    <= '0;
            r_fd    <= 1'b1;
            r_bd    <= 1'b1;
            r_bold  <= 1'b0;
            r_ul    <= 1'b0;
            r_bl    <= 1'b0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_priv  <= n_priv;
            r_fi    <= n_fi;
            r_bi    <= n_bi;
            r_fd    <= n_fd;
            r_bd    <= n_bd;
            r_bold  <= n_bold;
            r_ul    <= n_ul;
            r_bl    <= n_bl;
            r_rv    <= n_rv;
        end
        r_byte <= n_byte;
        r_idx  <= n_idx;
        r_walk <= n_walk;
        r_p0   <= n_p0;
        r_cmd  <= n_cmd;
        r_a    <= n_a;
        r_b    <= n_b;
        r_skip <= n_skip;
    end

    // Digit arithmetic: value * 10 + digit, saturating.
    logic [19:0] dig_sum;
    assign dig_sum = {4'd0, r_rdata} * 20'd10 + {16'd0, r_byte[3:0] - 4'd0};

    // The SGR parameter read back this cycle.
    logic [15:0] sv;
    assign sv = r_rdata;

    logic [CW-1:0] walk_n;
    assign walk_n = (r_count == '0) ? CW'(1) : r_count;

    // Next state, memory control and result.
    always_comb begin
        n_state = r_state; n_mode = r_mode; n_count = r_count; n_ovf = r_ovf;
        n_priv = r_priv; n_byte = r_byte; n_idx = r_idx; n_walk = r_walk;
        n_p0 = r_p0; n_fi = r_fi; n_bi = r_bi; n_fd = r_fd; n_bd = r_bd;
        n_bold = r_bold; n_ul = r_ul; n_bl = r_bl; n_rv = r_rv;
        n_cmd = r_cmd; n_a = r_a; n_b = r_b; n_skip = r_skip;
        rd_addr = '0; wr_addr = r_idx; wr_en = 1'b0; wr_data = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_byte = i_stream_byte;
                    n_a = '0;
                    n_b = '0;
                    case (r_mode)
                        MODE_ESCAPE: begin
                            n_mode = MODE_GROUND;
                            if (i_stream_byte == "[") begin
                                n_mode = MODE_CSI;
                                n_count = '0; n_ovf = 1'b0; n_priv = 1'b0;
                                n_idx = '0;
                                n_state = ST_CLEAR;
                            end else if (i_stream_byte == "7") begin
                                n_cmd = CMD_SAVE; n_state = ST_OUT;
                            end else if (i_stream_byte == "8") begin
                                n_cmd = CMD_RESTORE; n_state = ST_OUT;
                            end else if (i_stream_byte == "c") begin
                                n_fi = '0; n_bi = '0; n_fd = 1'b1; n_bd = 1'b1;
                                n_bold = 1'b0; n_ul = 1'b0; n_bl = 1'b0; n_rv = 1'b0;
                                n_cmd = CMD_RESET; n_state = ST_OUT;
                            end
                        end
                        MODE_CSI: begin
                            if (i_stream_byte >= "0" && i_stream_byte <= "9") begin
                                if (!r_ovf) begin
                                    if (r_count == '0) begin
                                        n_count = CW'(1);
                                        n_idx = '0;
                                    end else begin
                                        n_idx = (r_count > CMAX) ? ALAST
                                                                  : AW'(r_count - CW'(1));
                                    end
                                    rd_addr = n_idx;
                                    n_state = ST_DIGIT;
                                end
                            end else if (i_stream_byte == ";") begin
                                if (r_count == '0) begin
                                    n_count = (MAX_PARAMS > 1) ? CW'(2) : CW'(1);
                                    if (MAX_PARAMS <= 1) n_ovf = 1'b1;
                                end else if (r_count < CMAX) begin
                                    n_count = r_count + CW'(1);
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end else if (i_stream_byte == "?") begin
                                n_priv = 1'b1;
                            end else if (i_stream_byte >= 8'h40) begin
                                n_mode = MODE_GROUND;
                                rd_addr = '0;
                                n_state = ST_FIN0;
                            end
                        end
                        default: begin
                            n_mode = MODE_GROUND;
                            if (i_stream_byte == C_ESC) begin
                                n_mode = MODE_ESCAPE;
                            end else if (i_stream_byte < 8'h20) begin
                                n_state = ST_OUT;
                                case (i_stream_byte)
                                    8'h07: n_cmd = CMD_BELL;
                                    8'h08: n_cmd = CMD_BS;
                                    8'h09: n_cmd = CMD_TAB;
                                    8'h0A, 8'h0B, 8'h0C: n_cmd = CMD_LF;
                                    8'h0D: n_cmd = CMD_CR;
                                    default: n_state = ST_IDLE;
                                endcase
                            end else if (i_stream_byte != C_DEL) begin
                                n_cmd = CMD_CHAR;
                                n_a = {8'd0, i_stream_byte};
                                n_state = ST_OUT;
                            end
                        end
                    endcase
                end
            end

            // Clear one parameter entry a cycle.
            ST_CLEAR: begin
                wr_en = 1'b1; wr_addr = r_idx; wr_data = '0;
                if (r_idx == ALAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end

            // Write back the accumulated digit.
            ST_DIGIT: begin
                wr_en = 1'b1; wr_addr = r_idx;
                wr_data = (dig_sum > {4'd0, C_SAT}) ? C_SAT : dig_sum[15:0];
                n_state = ST_IDLE;
            end

            // First parameter arrives; fetch the second.
            ST_FIN0: begin
                n_p0 = (r_count == '0) ? 16'd0 : r_rdata;
                rd_addr = (MAX_PARAMS > 1) ? AW'(1) : '0;
                n_state = ST_FIN1;
            end

            // Second parameter arrives; decode the final byte.
            ST_FIN1: begin
                logic [15:0] p0d, p1d;
                p0d = (r_p0 == '0) ? 16'd1 : r_p0;
                p1d = (r_count < CW'(2) || MAX_PARAMS < 2 || r_rdata == '0)
                      ? 16'd1 : r_rdata;
                n_state = ST_OUT;
                case (r_byte)
                    "A": begin n_cmd = CMD_UP;   n_a = p0d; end
                    "B": begin n_cmd = CMD_DOWN; n_a = p0d; end
                    "C": begin n_cmd = CMD_FWD;  n_a = p0d; end
                    "D": begin n_cmd = CMD_BACK; n_a = p0d; end
                    "H", "f": begin
                        n_cmd = CMD_POS; n_a = p0d - 16'd1; n_b = p1d - 16'd1;
                    end
                    "J": begin n_cmd = CMD_ERASE_D; n_a = r_p0; end
                    "K": begin n_cmd = CMD_ERASE_L; n_a = r_p0; end
                    "s": n_cmd = CMD_SAVE;
                    "u": n_cmd = CMD_RESTORE;
                    "h": begin
                        n_cmd = CMD_SHOW;
                        if (!(r_priv && r_p0 == C_VIS)) n_state = ST_IDLE;
                    end
                    "l": begin
                        n_cmd = CMD_HIDE;
                        if (!(r_priv && r_p0 == C_VIS)) n_state = ST_IDLE;
                    end
                    "m": begin
                        n_cmd = CMD_ATTR;
                        n_walk = '0;
                        n_skip = '0;
                        rd_addr = '0;
                        n_state = ST_SGR;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            // One stored parameter per cycle; r_walk is the index now read.
            ST_SGR: begin
                if (r_skip == 3'd7 && sv == 16'd5) begin
                    // 38/48 followed by 5: one palette index follows.
                    n_skip = 3'd1;
                end else if (r_skip == 3'd7 && sv == 16'd2) begin
                    // 38/48 followed by 2: three colour components follow.
                    n_skip = 3'd3;
                end else if (r_skip != '0 && r_skip != 3'd7) begin
                    n_skip = r_skip - 3'd1;
                end else begin
                    // A plain parameter, also the one after 38/48 when it is not 5 or 2.
                    n_skip = '0;
                    if (sv == 16'd0) begin
                        n_fi = '0; n_bi = '0; n_fd = 1'b1; n_bd = 1'b1;
                        n_bold = 1'b0; n_ul = 1'b0; n_bl = 1'b0; n_rv = 1'b0;
                    end else if (sv == 16'd1) n_bold = 1'b1;
                    else if (sv == 16'd22) n_bold = 1'b0;
                    else if (sv == 16'd4) n_ul = 1'b1;
                    else if (sv == 16'd24) n_ul = 1'b0;
                    else if (sv == 16'd5) n_bl = 1'b1;
                    else if (sv == 16'd25) n_bl = 1'b0;
                    else if (sv == 16'd7) n_rv = 1'b1;
                    else if (sv == 16'd27) n_rv = 1'b0;
                    else if (sv == 16'd39) n_fd = 1'b1;
                    else if (sv == 16'd49) n_bd = 1'b1;
                    else if (sv == C_FG_EXT || sv == C_BG_EXT) begin
                        if (sv == C_FG_EXT) n_fd = 1'b1; else n_bd = 1'b1;
                        n_skip = 3'd7;
                    end else if (sv >= 16'd30 && sv <= 16'd37) begin
                        n_fi = 4'(sv - 16'd30); n_fd = 1'b0;
                    end else if (sv >= 16'd90 && sv <= 16'd97) begin
                        n_fi = 4'(sv - 16'd82); n_fd = 1'b0;
                    end else if (sv >= 16'd40 && sv <= 16'd47) begin
                        n_bi = 4'(sv - 16'd40); n_bd = 1'b0;
                    end else if (sv >= 16'd100 && sv <= 16'd107) begin
                        n_bi = 4'(sv - 16'd92); n_bd = 1'b0;
                    end
                end
                if (r_walk + CW'(1) >= walk_n) begin
                    n_state = ST_OUT;
                end else begin
                    n_walk = r_walk + CW'(1);
                    rd_addr = n_walk[AW-1:0];
                end
            end

            ST_OUT: begin
                if (!i_stall) n_state = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_command = r_cmd;
    assign o_arg_first = r_a;
    assign o_arg_second = r_b;
    assign o_fore_code = r_fd ? (r_bold ? 5'd15 : 5'd16)
                              : {1'b0, (r_bold && !r_fi[3]) ? (r_fi | 4'd8) : r_fi};
    assign o_back_code = r_bd ? 5'd16 : {1'b0, r_bi};
    assign o_underline_on = r_ul;
    assign o_blink_on = r_bl;
    assign o_reverse_on = r_rv;

    // Assertions.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMAX) else $error("parameter count beyond limit");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_command) && $stable(o_arg_first)))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT) |=> (r_state == ST_IDLE))
        else $error("digit write back took more than one cycle");
    a_clear_in_csi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (r_mode == MODE_CSI))
        else $error("memory clear outside CSI");

endmodule

// ===== tb/tb_ansi_escape_decoder.sv =====
// Testbench for ansi_escape_decoder: directed and random terminal byte streams,
// checked against a behavioral decoder kept in this file. Depends on aed_pkg and the RTL.
`timescale 1ns / 100ps

module tb_ansi_escape_decoder;
    import aed_pkg::*;

    localparam int NPARAM = 16;

    typedef struct packed {
        logic [4:0]  command;
        logic [15:0] arg_first;
        logic [15:0] arg_second;
        logic [4:0]  fore_code;
        logic [4:0]  back_code;
        logic        underline_on;
        logic        blink_on;
        logic        reverse_on;
    } t_term_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_stream_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_command;
    logic [15:0] o_arg_first;
    logic [15:0] o_arg_second;
    logic [4:0]  o_fore_code;
    logic [4:0]  o_back_code;
    logic        o_underline_on;
    logic        o_blink_on;
    logic        o_reverse_on;

    ansi_escape_decoder #(.MAX_PARAMS(NPARAM)) u_top (.*);

    always #2 i_clk = ~i_clk;

    // Decoder state mirrored by the predictor.
    t_mode       dec_mode;
    logic [15:0] dec_params [NPARAM];
    int          dec_count;
    logic        dec_over;
    logic        dec_priv;
    logic [3:0]  fg_idx, bg_idx;
    logic        fg_dflt, bg_dflt, bold, uline, blink, rev;

    logic [7:0]  byte_queue [$];
    t_term_cmd   cmd_queue [$];
    int          n_errors = 0;

    function automatic void attrs_clear();
        fg_idx = '0; bg_idx = '0; fg_dflt = 1'b1; bg_dflt = 1'b1;
        bold = 1'b0; uline = 1'b0; blink = 1'b0; rev = 1'b0;
    endfunction

    function automatic logic [15:0] param_dflt(int idx, logic [15:0] dflt);
        if (idx >= dec_count || dec_params[idx] == 16'd0) return dflt;
        return dec_params[idx];
    endfunction

    function automatic void push_cmd(t_cmd cmd, logic [15:0] a, logic [15:0] b);
        t_term_cmd r;
        r.command = cmd;
        r.arg_first = a;
        r.arg_second = b;
        if (fg_dflt) r.fore_code = bold ? 5'd15 : 5'd16;
        else r.fore_code = (bold && fg_idx < 4'd8) ? {1'b0, fg_idx} + 5'd8 : {1'b0, fg_idx};
        r.back_code = bg_dflt ? 5'd16 : {1'b0, bg_idx};
        r.underline_on = uline;
        r.blink_on = blink;
        r.reverse_on = rev;
        cmd_queue.push_back(r);
    endfunction

    function automatic void apply_sgr();
        int n;
        int v;
        n = (dec_count == 0) ? 1 : dec_count;
        for (int i = 0; i < n; i++) begin
            v = dec_params[i];
            if (v == 0) attrs_clear();
            else if (v == 1) bold = 1'b1;
            else if (v == 22) bold = 1'b0;
            else if (v == 4) uline = 1'b1;
            else if (v == 24) uline = 1'b0;
            else if (v == 5) blink = 1'b1;
            else if (v == 25) blink = 1'b0;
            else if (v == 7) rev = 1'b1;
            else if (v == 27) rev = 1'b0;
            else if (v == 39) fg_dflt = 1'b1;
            else if (v == 49) bg_dflt = 1'b1;
            else if (v == 38 || v == 48) begin
                // Extended colours are skipped and fall back to the default.
                if (i + 1 < n && dec_params[i+1] == 16'd5) i += 2;
                else if (i + 1 < n && dec_params[i+1] == 16'd2) i += 4;
                if (v == 38) fg_dflt = 1'b1; else bg_dflt = 1'b1;
            end else if (v >= 30 && v <= 37) begin
                fg_idx = 4'(v - 30); fg_dflt = 1'b0;
            end else if (v >= 90 && v <= 97) begin
                fg_idx = 4'(v - 82); fg_dflt = 1'b0;
            end else if (v >= 40 && v <= 47) begin
                bg_idx = 4'(v - 40); bg_dflt = 1'b0;
            end else if (v >= 100 && v <= 107) begin
                bg_idx = 4'(v - 92); bg_dflt = 1'b0;
            end
        end
    endfunction

    // Predicts the command caused by one stream byte.
    function automatic void decode_byte(logic [7:0] c);
        int idx;
        int v;
        logic [15:0] sel;
        if (dec_mode == MODE_ESCAPE) begin
            dec_mode = MODE_GROUND;
            if (c == "[") begin
                dec_mode = MODE_CSI;
                foreach (dec_params[i]) dec_params[i] = '0;
                dec_count = 0; dec_over = 1'b0; dec_priv = 1'b0;
            end else if (c == "7") push_cmd(CMD_SAVE, 16'd0, 16'd0);
            else if (c == "8") push_cmd(CMD_RESTORE, 16'd0, 16'd0);
            else if (c == "c") begin
                attrs_clear();
                push_cmd(CMD_RESET, 16'd0, 16'd0);
            end
        end else if (dec_mode == MODE_CSI) begin
            if (c >= "0" && c <= "9") begin
                if (!dec_over) begin
                    if (dec_count == 0) dec_count = 1;
                    idx = dec_count - 1;
                    v = dec_params[idx] * 10 + (c - "0");
                    dec_params[idx] = (v > 65535) ? C_SAT : v[15:0];
                end
            end else if (c == ";") begin
                if (dec_count == 0) dec_count = 1;
                if (dec_count < NPARAM) dec_count++;
                else dec_over = 1'b1;
            end else if (c == "?") dec_priv = 1'b1;
            else if (c >= 8'h40) begin
                dec_mode = MODE_GROUND;
                sel = (dec_count > 0) ? dec_params[0] : 16'd0;
                case (c)
                    "A": push_cmd(CMD_UP, param_dflt(0, 16'd1), 16'd0);
                    "B": push_cmd(CMD_DOWN, param_dflt(0, 16'd1), 16'd0);
                    "C": push_cmd(CMD_FWD, param_dflt(0, 16'd1), 16'd0);
                    "D": push_cmd(CMD_BACK, param_dflt(0, 16'd1), 16'd0);
                    "H", "f": push_cmd(CMD_POS, param_dflt(0, 16'd1) - 16'd1,
                                       param_dflt(1, 16'd1) - 16'd1);
                    "J": push_cmd(CMD_ERASE_D, sel, 16'd0);
                    "K": push_cmd(CMD_ERASE_L, sel, 16'd0);
                    "s": push_cmd(CMD_SAVE, 16'd0, 16'd0);
                    "u": push_cmd(CMD_RESTORE, 16'd0, 16'd0);
                    "h": if (dec_priv && param_dflt(0, 16'd0) == C_VIS)
                        push_cmd(CMD_SHOW, 16'd0, 16'd0);
                    "l": if (dec_priv && param_dflt(0, 16'd0) == C_VIS)
                        push_cmd(CMD_HIDE, 16'd0, 16'd0);
                    "m": begin
                        apply_sgr();
                        push_cmd(CMD_ATTR, 16'd0, 16'd0);
                    end
                    default: ;
                endcase
            end
        end else begin
            if (c == C_ESC) dec_mode = MODE_ESCAPE;
            else if (c < 8'h20) begin
                case (c)
                    8'h07: push_cmd(CMD_BELL, 16'd0, 16'd0);
                    8'h08: push_cmd(CMD_BS, 16'd0, 16'd0);
                    8'h09: push_cmd(CMD_TAB, 16'd0, 16'd0);
                    8'h0A, 8'h0B, 8'h0C: push_cmd(CMD_LF, 16'd0, 16'd0);
                    8'h0D: push_cmd(CMD_CR, 16'd0, 16'd0);
                    default: ;
                endcase
            end else if (c != C_DEL) push_cmd(CMD_CHAR, {8'h00, c}, 16'd0);
        end
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: presents queued bytes with random gaps between them.
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall) begin
            // Held until accepted.
        end else if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall && byte_queue.size() == 0) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                drv_gap <= pick_gap();
            end
            if (byte_queue.size() > 0 && !(i_valid && !o_stall && $urandom_range(0, 1))) begin
                i_stream_byte <= byte_queue[0];
                decode_byte(byte_queue.pop_front());
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall.
    int mon_gap = 0;
    always @(posedge i_clk) begin
        t_term_cmd exp_cmd;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cmd_queue.size() == 0) begin
                $error("command exp none got %0d", o_command);
                n_errors++;
            end else begin
                exp_cmd = cmd_queue.pop_front();
                if (o_command !== exp_cmd.command) begin
                    $error("command exp %0d got %0d", exp_cmd.command, o_command); n_errors++;
                end
                if (o_arg_first !== exp_cmd.arg_first) begin
                    $error("arg_first exp %0d got %0d", exp_cmd.arg_first, o_arg_first); n_errors++;
                end
                if (o_arg_second !== exp_cmd.arg_second) begin
                    $error("arg_second exp %0d got %0d", exp_cmd.arg_second, o_arg_second);
                    n_errors++;
                end
                if (o_fore_code !== exp_cmd.fore_code) begin
                    $error("fore_code exp %0d got %0d", exp_cmd.fore_code, o_fore_code); n_errors++;
                end
                if (o_back_code !== exp_cmd.back_code) begin
                    $error("back_code exp %0d got %0d", exp_cmd.back_code, o_back_code); n_errors++;
                end
                if (o_underline_on !== exp_cmd.underline_on) begin
                    $error("underline_on exp %0d got %0d", exp_cmd.underline_on, o_underline_on);
                    n_errors++;
                end
                if (o_blink_on !== exp_cmd.blink_on) begin
                    $error("blink_on exp %0d got %0d", exp_cmd.blink_on, o_blink_on); n_errors++;
                end
                if (o_reverse_on !== exp_cmd.reverse_on) begin
                    $error("reverse_on exp %0d got %0d", exp_cmd.reverse_on, o_reverse_on);
                    n_errors++;
                end
            end
        end
        if (mon_gap > 0) begin
            mon_gap <= mon_gap - 1;
            i_stall <= 1'b1;
        end else begin
            mon_gap <= pick_gap();
            i_stall <= 1'b0;
        end
    end

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
    endtask

    // One random CSI sequence, mostly well formed.
    task automatic push_csi();
        string fin = "ABCDHfJKsuhlmmmmXq";
        int np;
        int k;
        push_str("\033[");
        if ($urandom_range(0, 3) == 0) byte_queue.push_back("?");
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 4);
        for (int i = 0; i < np; i++) begin
            if (i > 0) byte_queue.push_back(";");
            k = $urandom_range(0, 9);
            if (k < 5) begin
                int vals[] = '{0, 1, 4, 5, 7, 22, 24, 25, 27, 30, 37, 38, 39, 40, 47,
                               48, 49, 90, 97, 100, 107, 2};
                push_str($sformatf("%0d", vals[$urandom_range(0, vals.size() - 1)]));
            end else if (k < 8) push_str($sformatf("%0d", $urandom_range(0, 999)));
            else if (k < 9) push_str($sformatf("%0d", $urandom_range(0, 9999999)));
        end
        if ($urandom_range(0, 7) == 0) byte_queue.push_back(8'($urandom_range(0, 8'h3F)));
        if ($urandom_range(0, 7) == 0) byte_queue.push_back(8'($urandom_range(8'h40, 8'hFF)));
        else byte_queue.push_back(fin[$urandom_range(0, fin.len() - 1)]);
    endtask

    initial begin
        string esc_fin;
        esc_fin = "78c[";
        dec_mode = MODE_GROUND;
        foreach (dec_params[i]) dec_params[i] = '0;
        dec_count = 0; dec_over = 1'b0; dec_priv = 1'b0;
        attrs_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: controls, extremes, escapes, moves, visibility, SGR, overflow.
        push_str("\007\010\011\012\013\014\015\001\177 ~");
        byte_queue.push_back(8'h80); byte_queue.push_back(8'hFF);
        push_str("\0337\0338\033x\033[A\033[0;0H\033[99999;7f\033[?25h\033[25l");
        push_str("\033[1;4;5;7;31;42m\033[38;5;1;48;2;1;2;3;97;107m\033c");
        push_str("\033[2J\033[K\033[3C\033[;5B\033[D\033[\033\001?25lZ");
        push_str("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18m");
        push_str("\033[38;1;48;4m\033[48;7m");

        // Random stream up to about 400 bytes in all.
        while (byte_queue.size() < 400) begin
            if ($urandom_range(0, 9) < 6) begin
                push_csi();
            end else if ($urandom_range(0, 3) == 0) begin
                byte_queue.push_back(C_ESC);
                if ($urandom_range(0, 9) < 6)
                    byte_queue.push_back(esc_fin[$urandom_range(0, 3)]);
                else
                    byte_queue.push_back(8'($urandom_range(0, 255)));
            end else begin
                byte_queue.push_back(8'($urandom_range(0, 255)));
            end
        end
        push_str("\033[0m");

        wait (byte_queue.size() == 0 && !i_valid);
        wait (cmd_queue.size() == 0);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && cmd_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #8ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
